>>> sv/agvg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agvg_pkg
// Shared types and constants of the gained-capture voice gate.
// ----------------------------------------------------------------------------
package agvg_pkg;

  localparam int MAX_FRAME_SAMPLES = 4096;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int VOLUME_W  = 16;
  localparam int HOLD_W    = 16;
  localparam int THRESH_W  = 16;
  localparam int FRAME_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Gain is Q6.10: the product is shifted down by this many bits.
  localparam int GAIN_FRAC_W = 10;

  // Square of a saturated 16-bit sample, at most 2^30.
  localparam int SQ_W = 31;

  // 32767 squared, the full-scale energy of one sample.
  localparam int FS_SQ_W = 30;
  localparam logic [FS_SQ_W-1:0] FULL_SCALE_SQ = 30'd1073676289;

  localparam int QUO_W  = 32;
  localparam int ROOT_W = 16;

  localparam int JOB_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd1024;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd0;
  localparam logic [HOLD_W-1:0]  HOLD_RESET   = 16'd250;
  localparam logic [FRAME_W-1:0] FRAME_RESET  = 13'd1920;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_FACTOR  = 2'd0,
    CFG_THRESHOLD    = 2'd1,
    CFG_HOLD_MS      = 2'd2,
    CFG_FRAME_LENGTH = 2'd3
  } cfg_index_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                       opcode;
    logic signed [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] gained_sample;
    logic                       frame_end;
    logic [VOLUME_W-1:0]        volume;
    logic                       voice_active;
  } out_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic                       tick;
    logic signed [SAMPLE_W-1:0] gained;
  } job_t;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    logic [HOLD_W-1:0]   hold_ms;
    logic [FRAME_W-1:0]  frame_length;
  } gate_cfg_t;

endpackage

>>> sv/agvg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agvg_queue
// Small register queue of DEPTH entries; data shows while not empty.
// ----------------------------------------------------------------------------
module agvg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> sv/agvg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agvg_front
// Accepts items, applies the Q6.10 gain with rounding and saturation.
// ----------------------------------------------------------------------------
module agvg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  agvg_pkg::in_t                 cmd,
  input  logic [agvg_pkg::GAIN_W-1:0]   gain_factor,
  output logic                          job_wr,
  output agvg_pkg::job_t                job,
  input  logic                          job_full
);

  localparam int PROD_W = agvg_pkg::SAMPLE_W + agvg_pkg::GAIN_W;
  localparam int MAG_W  = PROD_W - agvg_pkg::GAIN_FRAC_W;

  agvg_pkg::in_t                  stage;
  logic                           stage_valid;
  logic                           take;
  logic                           neg;
  logic [agvg_pkg::SAMPLE_W:0]    mag_wide;
  logic [agvg_pkg::SAMPLE_W-1:0]  mag;
  logic [PROD_W-1:0]              prod;
  logic [PROD_W-1:0]              rounded;
  logic [MAG_W-1:0]               rmag;
  logic [agvg_pkg::SAMPLE_W-1:0]  gained;

  assign full   = stage_valid && job_full;
  assign take   = push && !full;
  assign job_wr = stage_valid;

  // Magnitude of -32768 still fits in 16 unsigned bits.
  assign neg      = stage.sample[agvg_pkg::SAMPLE_W-1];
  assign mag_wide = neg ? ((agvg_pkg::SAMPLE_W+1)'(0) - {stage.sample[agvg_pkg::SAMPLE_W-1],
                                                         stage.sample})
                        : {1'b0, stage.sample};
  assign mag      = mag_wide[agvg_pkg::SAMPLE_W-1:0];
  assign prod     = {{agvg_pkg::GAIN_W{1'b0}}, mag} * {{agvg_pkg::SAMPLE_W{1'b0}}, gain_factor};
  assign rounded  = prod + PROD_W'(1 << (agvg_pkg::GAIN_FRAC_W - 1));
  assign rmag     = rounded[PROD_W-1:agvg_pkg::GAIN_FRAC_W];

  always_comb begin
    if (neg) begin
      if (rmag >= MAG_W'(32768)) begin
        gained = 16'h8000;
      end else begin
        gained = 16'(~rmag[agvg_pkg::SAMPLE_W-1:0] + 1'b1);
      end
    end else begin
      if (rmag >= MAG_W'(32767)) begin
        gained = 16'h7FFF;
      end else begin
        gained = rmag[agvg_pkg::SAMPLE_W-1:0];
      end
    end
  end

  always_comb begin
    job.tick   = (agvg_pkg::opcode_t'(stage.opcode) == agvg_pkg::OP_TICK);
    job.gained = job.tick ? '0 : $signed(gained);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (!job_full) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage <= cmd;
    end
  end

endmodule

>>> sv/agvg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agvg_back
// Frame energy accumulator, volume engine (divider and root) and hangover.
// ----------------------------------------------------------------------------
module agvg_back #(
  parameter int MAX_FRAME_SAMPLES = agvg_pkg::MAX_FRAME_SAMPLES
) (
  input  logic                clk,
  input  logic                rst,
  input  agvg_pkg::gate_cfg_t cfg,
  input  logic                job_valid,
  input  agvg_pkg::job_t      job,
  output logic                job_rd,
  output logic                res_wr,
  output agvg_pkg::out_t      res,
  input  logic                res_full
);

  localparam int N_W     = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W   = N_W + agvg_pkg::SQ_W - 1;
  localparam int DEN_W   = N_W + agvg_pkg::FS_SQ_W;
  localparam int QUO_W   = agvg_pkg::QUO_W;
  localparam int ROOT_W  = agvg_pkg::ROOT_W;
  localparam int STEP_W  = $clog2(QUO_W);
  localparam int RBIT_W  = $clog2(ROOT_W);
  localparam int SW      = agvg_pkg::SAMPLE_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t                   state, state_next;
  logic [N_W-1:0]           cnt, cnt_next;
  logic [SUM_W-1:0]         sum, sum_next;
  logic                     active, active_next;
  logic [agvg_pkg::HOLD_W-1:0] hold, hold_next;
  logic [DEN_W-1:0]         den, den_next;
  logic [DEN_W-1:0]         rem, rem_next;
  logic [QUO_W-1:0]         quo, quo_next;
  logic [ROOT_W-1:0]        root, root_next;
  logic [STEP_W-1:0]        step, step_next;
  logic                     ovf, ovf_next;
  logic signed [SW-1:0]     gfrm, gfrm_next;

  logic [31:0]              n_wide;
  logic [N_W-1:0]           n;
  logic [N_W-1:0]           cnt_inc;
  logic [SW-1:0]            gabs;
  logic [2*SW-1:0]          gsq;
  logic [SUM_W-1:0]         sum_inc;
  logic [DEN_W:0]           two_sum;
  logic [DEN_W:0]           rem2;
  logic                     rem_ge;
  logic [DEN_W:0]           rem_sub;
  logic [ROOT_W-1:0]        cand;
  logic [2*ROOT_W-1:0]      cand_sq;
  logic [ROOT_W-1:0]        vol;

  // Frame length of zero acts as one; above the maximum it is clamped.
  always_comb begin
    if (cfg.frame_length == '0) begin
      n_wide = 32'd1;
    end else if (32'(cfg.frame_length) > 32'(MAX_FRAME_SAMPLES)) begin
      n_wide = 32'(MAX_FRAME_SAMPLES);
    end else begin
      n_wide = 32'(cfg.frame_length);
    end
  end
  assign n = n_wide[N_W-1:0];

  assign cnt_inc = cnt + 1'b1;
  assign gabs    = job.gained[SW-1] ? SW'(-job.gained) : SW'(job.gained);
  assign gsq     = {{SW{1'b0}}, gabs} * {{SW{1'b0}}, gabs};
  assign sum_inc = sum + SUM_W'(gsq[agvg_pkg::SQ_W-1:0]);

  assign two_sum = {sum, 1'b0};
  assign rem2    = {rem, 1'b0};
  assign rem_ge  = rem2 >= {1'b0, den};
  assign rem_sub = rem2 - {1'b0, den};

  assign cand    = root | (ROOT_W'(1) << (RBIT_W'(ROOT_W - 1) - step[RBIT_W-1:0]));
  assign cand_sq = {{ROOT_W{1'b0}}, cand} * {{ROOT_W{1'b0}}, cand};
  assign vol     = ovf ? {ROOT_W{1'b1}} : root;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    sum_next    = sum;
    active_next = active;
    hold_next   = hold;
    den_next    = den;
    rem_next    = rem;
    quo_next    = quo;
    root_next   = root;
    step_next   = step;
    ovf_next    = ovf;
    gfrm_next   = gfrm;
    job_rd      = 1'b0;
    res_wr      = 1'b0;
    res         = '0;

    unique case (state)
      ST_IDLE: begin
        if (job_valid && !res_full) begin
          job_rd = 1'b1;
          if (job.tick) begin
            if (active) begin
              if (hold <= agvg_pkg::HOLD_W'(1)) begin
                hold_next   = '0;
                active_next = 1'b0;
              end else begin
                hold_next = hold - 1'b1;
              end
            end
            res_wr           = 1'b1;
            res.voice_active = active_next;
          end else if (cnt_inc >= n) begin
            // This sample closes the frame; its result waits for the volume.
            sum_next   = sum_inc;
            cnt_next   = '0;
            gfrm_next  = job.gained;
            state_next = ST_MUL;
          end else begin
            sum_next          = sum_inc;
            cnt_next          = cnt_inc;
            res_wr            = 1'b1;
            res.gained_sample = job.gained;
            res.voice_active  = active;
          end
        end
      end
      ST_MUL: begin
        den_next   = {{(DEN_W-N_W){1'b0}}, n} *
                     {{N_W{1'b0}}, agvg_pkg::FULL_SCALE_SQ};
        state_next = ST_CHK;
      end
      ST_CHK: begin
        // The scaled quotient reaches 2^32 exactly when 2*sum >= n*32767^2,
        // and then the volume saturates at full scale.
        if (two_sum >= {1'b0, den}) begin
          ovf_next   = 1'b1;
          state_next = ST_EMIT;
        end else begin
          ovf_next   = 1'b0;
          rem_next   = two_sum[DEN_W-1:0];
          quo_next   = '0;
          step_next  = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_next = rem_ge ? rem_sub[DEN_W-1:0] : rem2[DEN_W-1:0];
        quo_next = {quo[QUO_W-2:0], rem_ge};
        if (step == STEP_W'(QUO_W - 1)) begin
          step_next  = '0;
          root_next  = '0;
          state_next = ST_SQRT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_SQRT: begin
        if (cand_sq <= quo) begin
          root_next = cand;
        end
        if (step == STEP_W'(ROOT_W - 1)) begin
          state_next = ST_EMIT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!res_full) begin
          res_wr            = 1'b1;
          res.gained_sample = gfrm;
          res.frame_end     = 1'b1;
          if (vol >= cfg.threshold) begin
            active_next = 1'b1;
            hold_next   = cfg.hold_ms;
            res.volume  = vol;
          end else begin
            res.volume = active ? vol : '0;
          end
          res.voice_active = active_next;
          sum_next         = '0;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      sum    <= '0;
      active <= 1'b0;
      hold   <= '0;
      step   <= '0;
      ovf    <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      sum    <= sum_next;
      active <= active_next;
      hold   <= hold_next;
      step   <= step_next;
      ovf    <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    den  <= den_next;
    rem  <= rem_next;
    quo  <= quo_next;
    root <= root_next;
    gfrm <= gfrm_next;
  end

  a_hold_clear_when_inactive: assert property (@(posedge clk) disable iff (rst)
    !active |-> (hold == '0))
    else $error("hold counter nonzero while voice is inactive");

  a_result_room: assert property (@(posedge clk) disable iff (rst)
    res_wr |-> !res_full)
    else $error("result written into a full queue");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    job_rd |-> (state == ST_IDLE && job_valid))
    else $error("job taken outside of the idle state");

  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && res_wr) |=> (sum == '0 && cnt == '0 && state == ST_IDLE))
    else $error("frame accumulator not cleared after frame end");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt < N_W'(MAX_FRAME_SAMPLES))
    else $error("sample count beyond the frame maximum");

endmodule

>>> sv/audio_gain_rms_voice_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_gain_rms_voice_gate
// Capture gain with RMS voice detection per frame and tick-driven hangover.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  cmd       in         push / full        opcode, sample
//  result    out        empty / pop        gained_sample, frame_end, volume,
//                                          voice_active
//  cfg       in         cfg_valid/ready    cfg_index, cfg_data
//
//  A tick or a sample that does not close a frame passes the front stage and
//  is then handled in the back part's idle state. A sample that closes a frame
//  goes through one multiply, one range check, a 32-step restoring divider and
//  a 16-step square root (both skipped on saturation), then the result transfer.
//  Reset is synchronous; the configuration takes its reset values and the
//  frame, voice flag and hold counter are cleared. Either side may stall:
//  job and result queues of two entries decouple front, back and output.
// ----------------------------------------------------------------------------
module audio_gain_rms_voice_gate #(
  parameter int MAX_FRAME_SAMPLES = agvg_pkg::MAX_FRAME_SAMPLES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  agvg_pkg::in_t                      cmd,
  output logic                               empty,
  input  logic                               pop,
  output agvg_pkg::out_t                     result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [agvg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [agvg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int JOB_W = $bits(agvg_pkg::job_t);
  localparam int RES_W = $bits(agvg_pkg::out_t);

  logic [agvg_pkg::GAIN_W-1:0] gain_factor;
  agvg_pkg::gate_cfg_t         gate_cfg;

  logic                        job_wr;
  agvg_pkg::job_t              job_in;
  logic                        job_full;
  logic                        job_empty;
  logic                        job_rd;
  logic [JOB_W-1:0]            job_bits;
  agvg_pkg::job_t              job_out;

  logic                        res_wr;
  agvg_pkg::out_t              res_in;
  logic                        res_full;
  logic [RES_W-1:0]            res_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_factor           <= agvg_pkg::GAIN_RESET;
      gate_cfg.threshold    <= agvg_pkg::THRESH_RESET;
      gate_cfg.hold_ms      <= agvg_pkg::HOLD_RESET;
      gate_cfg.frame_length <= agvg_pkg::FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (agvg_pkg::cfg_index_t'(cfg_index))
        agvg_pkg::CFG_GAIN_FACTOR:  gain_factor <= cfg_data;
        agvg_pkg::CFG_THRESHOLD:    gate_cfg.threshold <= cfg_data;
        agvg_pkg::CFG_HOLD_MS:      gate_cfg.hold_ms <= cfg_data;
        agvg_pkg::CFG_FRAME_LENGTH: begin
          gate_cfg.frame_length <= cfg_data[agvg_pkg::FRAME_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  agvg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .gain_factor (gain_factor),
    .job_wr      (job_wr),
    .job         (job_in),
    .job_full    (job_full)
  );

  agvg_queue #(
    .WIDTH (JOB_W),
    .DEPTH (agvg_pkg::JOB_QUEUE_DEPTH)
  ) u_job_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_wr),
    .wr_data (job_in),
    .full    (job_full),
    .rd      (job_rd),
    .rd_data (job_bits),
    .empty   (job_empty)
  );

  assign job_out = job_bits;

  agvg_back #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (gate_cfg),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_rd    (job_rd),
    .res_wr    (res_wr),
    .res       (res_in),
    .res_full  (res_full)
  );

  agvg_queue #(
    .WIDTH (RES_W),
    .DEPTH (agvg_pkg::RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd      (pop),
    .rd_data (res_bits),
    .empty   (empty)
  );

  assign result = res_bits;

endmodule

>>> bench/tb_audio_gain_rms_voice_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_gain_rms_voice_gate
// Self-checking bench for the gained capture path with frame RMS voice gate.
// A queue-fed driver sends samples and ticks with random gaps, and a monitor
// pops results with random stalls. Every result is checked against a
// cycle-free prediction of gain, frame volume and hangover. Registers are
// rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb_audio_gain_rms_voice_gate;

  localparam int WATCH_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_PRINTED   = 100;
  localparam int SW            = agvg_pkg::SAMPLE_W;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            push = 1'b0;
  logic                            full;
  agvg_pkg::in_t                   cmd = '0;
  logic                            empty;
  logic                            pop = 1'b0;
  agvg_pkg::out_t                  result;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [agvg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [agvg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted register copies and gate state.
  logic [agvg_pkg::GAIN_W-1:0]   gain_q;
  logic [agvg_pkg::THRESH_W-1:0] thresh_lvl;
  logic [agvg_pkg::HOLD_W-1:0]   hang_ms;
  logic [agvg_pkg::FRAME_W-1:0]  frame_len;
  int unsigned                   frame_fill;
  longint unsigned               energy;
  logic                          voice_on;
  logic [agvg_pkg::HOLD_W-1:0]   hang_left;

  agvg_pkg::in_t  cmd_backlog[$];
  agvg_pkg::out_t gated_out_q[$];

  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned err_cnt = 0;
  int unsigned res_seen = 0;
  int unsigned quiet_cycles = 0;

  audio_gain_rms_voice_gate i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_err(string msg);
    err_cnt++;
    // Past a hundred lines only the count goes on.
    if (err_cnt <= MAX_PRINTED) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic int unsigned gap_draw(bit on);
    return on ? $urandom_range(0, 14) : 0;
  endfunction

  function automatic logic signed [SW-1:0] scale_sample(logic signed [SW-1:0] s);
    int              sv;
    longint unsigned mag;
    longint unsigned r;
    sv  = int'(s);
    mag = (sv < 0) ? longint'(-sv) : longint'(sv);
    r   = (mag * 64'(gain_q) + 64'd512) >> agvg_pkg::GAIN_FRAC_W;
    if (sv < 0) begin
      if (r >= 64'd32768) return 16'sh8000;
      return $signed(SW'(-r));
    end
    if (r >= 64'd32767) return 16'sh7FFF;
    return $signed(SW'(r));
  endfunction

  // Largest level v with v^2 * n * 32767^2 <= sum * 2^33, found bit by bit.
  function automatic logic [agvg_pkg::VOLUME_W-1:0] rms_level(longint unsigned sum,
                                                              int unsigned n);
    logic [79:0]                   rhs;
    logic [79:0]                   lhs;
    logic [79:0]                   cw;
    logic [79:0]                   nw;
    logic [79:0]                   fw;
    logic [agvg_pkg::VOLUME_W-1:0] v;
    logic [agvg_pkg::VOLUME_W-1:0] c;
    rhs = 80'(sum) << 33;
    nw  = 80'(n);
    fw  = 80'(agvg_pkg::FULL_SCALE_SQ);
    v   = '0;
    for (int b = agvg_pkg::VOLUME_W - 1; b >= 0; b--) begin
      c   = v | (16'd1 << b);
      cw  = 80'(c);
      lhs = cw * cw * nw * fw;
      if (lhs <= rhs) v = c;
    end
    return v;
  endfunction

  task automatic track_gate(agvg_pkg::in_t it);
    agvg_pkg::out_t o;
    int             g;
    int unsigned    n;
    o = '0;
    if (it.opcode == agvg_pkg::OP_TICK) begin
      if (voice_on) begin
        if (hang_left <= 1) begin
          hang_left = '0;
          voice_on  = 1'b0;
        end else begin
          hang_left = hang_left - 1'b1;
        end
      end
    end else begin
      o.gained_sample = scale_sample(it.sample);
      g = int'(o.gained_sample);
      energy = energy + longint'(g * g);
      frame_fill++;
      n = 32'(frame_len);
      if (n < 1) n = 1;
      if (n > agvg_pkg::MAX_FRAME_SAMPLES) n = agvg_pkg::MAX_FRAME_SAMPLES;
      // A frame length lowered below the current fill closes on this sample.
      if (frame_fill >= n) begin
        o.frame_end = 1'b1;
        o.volume    = rms_level(energy, n);
        if (o.volume >= thresh_lvl) begin
          voice_on  = 1'b1;
          hang_left = hang_ms;
        end else if (!voice_on) begin
          o.volume = '0;
        end
        frame_fill = 0;
        energy     = 0;
      end
    end
    o.voice_active = voice_on;
    gated_out_q.push_back(o);
  endtask

  // Command side: holds an item until its transfer, then waits a random gap.
  always @(posedge clk) begin
    if (rst) begin
      push      <= 1'b0;
      send_wait <= 0;
    end else begin
      if (push && !full) track_gate(cmd);
      if (!push || !full) begin
        if (send_wait != 0) begin
          push      <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (cmd_backlog.size() != 0) begin
          cmd       <= cmd_backlog.pop_front();
          push      <= 1'b1;
          send_wait <= gap_draw(send_idle);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result side: checks each transfer, then stalls pop for a random while.
  always @(posedge clk) begin : result_side
    int unsigned    nw;
    agvg_pkg::out_t want;
    if (rst) begin
      pop       <= 1'b0;
      recv_wait <= 0;
    end else begin
      nw = recv_wait;
      if (pop && !empty) begin
        res_seen++;
        nw = gap_draw(recv_idle);
        if (gated_out_q.size() == 0) begin
          report_err($sformatf("result %0d arrived with nothing pending", res_seen));
        end else begin
          want = gated_out_q.pop_front();
          if (result.gained_sample !== want.gained_sample)
            report_err($sformatf("result %0d gained_sample %0d, expected %0d", res_seen,
                                 result.gained_sample, want.gained_sample));
          if (result.frame_end !== want.frame_end)
            report_err($sformatf("result %0d frame_end %0b, expected %0b", res_seen,
                                 result.frame_end, want.frame_end));
          if (result.volume !== want.volume)
            report_err($sformatf("result %0d volume %0d, expected %0d", res_seen,
                                 result.volume, want.volume));
          if (result.voice_active !== want.voice_active)
            report_err($sformatf("result %0d voice_active %0b, expected %0b", res_seen,
                                 result.voice_active, want.voice_active));
        end
      end
      if (nw != 0) begin
        pop       <= 1'b0;
        recv_wait <= nw - 1;
      end else begin
        pop       <= 1'b1;
        recv_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("audio_gain_rms_voice_gate regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(agvg_pkg::cfg_index_t idx,
                           logic [agvg_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      agvg_pkg::CFG_GAIN_FACTOR:  gain_q     = val;
      agvg_pkg::CFG_THRESHOLD:    thresh_lvl = val;
      agvg_pkg::CFG_HOLD_MS:      hang_ms    = val;
      agvg_pkg::CFG_FRAME_LENGTH: frame_len  = val[agvg_pkg::FRAME_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_gate(logic [15:0] g, logic [15:0] t, logic [15:0] h, logic [15:0] f);
    write_reg(agvg_pkg::CFG_GAIN_FACTOR, g);
    write_reg(agvg_pkg::CFG_THRESHOLD, t);
    write_reg(agvg_pkg::CFG_HOLD_MS, h);
    write_reg(agvg_pkg::CFG_FRAME_LENGTH, f);
  endtask

  task automatic add_sample(logic signed [SW-1:0] s);
    agvg_pkg::in_t it;
    it.opcode = agvg_pkg::OP_SAMPLE;
    it.sample = s;
    cmd_backlog.push_back(it);
  endtask

  task automatic add_tick();
    agvg_pkg::in_t it;
    it.opcode = agvg_pkg::OP_TICK;
    it.sample = SW'($urandom_range(0, 65535));
    cmd_backlog.push_back(it);
  endtask

  // The sender stops here until every predicted result has been popped.
  task automatic drain();
    while (cmd_backlog.size() != 0 || push || gated_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] draw_sample(int unsigned amp);
    logic [SW-1:0] mag;
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3, 4: return SW'($urandom_range(0, 65535));
      default: begin
        mag = SW'($urandom_range(0, (1 << amp) - 1));
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  initial begin
    logic [15:0] g;
    logic [15:0] t;
    logic [15:0] h;
    logic [15:0] f;
    int unsigned amp;

    gain_q     = agvg_pkg::GAIN_RESET;
    thresh_lvl = agvg_pkg::THRESH_RESET;
    hang_ms    = agvg_pkg::HOLD_RESET;
    frame_len  = agvg_pkg::FRAME_RESET;
    frame_fill = 0;
    energy     = 0;
    voice_on   = 1'b0;
    hang_left  = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a tick while inactive, then a partial long frame.
    add_tick();
    add_sample(16'sd32767);
    add_sample(16'sh8000);
    add_sample(16'sd1);
    add_sample(-16'sd1);
    drain();

    // Maximum gain and threshold, no hangover, frame length 0 acting as 1.
    set_gate(16'd65535, 16'd65535, 16'd0, 16'd0);
    add_sample(16'sd0);
    add_sample(16'sd32767);
    add_tick();
    add_sample(16'sh8000);
    add_sample(16'sd1);
    add_tick();
    add_sample(16'sd1);
    drain();

    // Half gain: ties round away from zero.
    set_gate(16'd512, 16'd0, 16'd2, 16'd4096);
    add_sample(16'sd1);
    add_sample(-16'sd1);
    add_sample(16'sd3);
    add_sample(-16'sd3);
    add_sample(16'sd2);
    add_tick();
    drain();

    // Frame length lowered below the fill; threshold zero makes it loud.
    write_reg(agvg_pkg::CFG_GAIN_FACTOR, 16'd511);
    write_reg(agvg_pkg::CFG_FRAME_LENGTH, 16'd3);
    add_sample(16'sd1);
    add_tick();
    add_tick();
    add_tick();
    add_sample(16'sd32767);
    add_sample(16'sh8000);
    add_sample(16'sd32767);
    add_tick();
    add_tick();
    drain();

    // Random phases, the first two pinned to register extremes.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_gate(16'd0, 16'd65535, 16'd65535, 16'd1);
        1: set_gate(16'd65535, 16'd0, 16'd65535, 16'd2);
        default: begin
          case ($urandom_range(0, 4))
            0: g = 16'd0;
            1: g = 16'd65535;
            2: g = 16'd1024;
            3: g = 16'($urandom_range(0, 4095));
            default: g = 16'($urandom_range(0, 65535));
          endcase
          case ($urandom_range(0, 3))
            0: t = 16'd0;
            1: t = 16'd65535;
            default: t = 16'($urandom_range(0, 65535));
          endcase
          case ($urandom_range(0, 4))
            0: h = 16'd0;
            1: h = 16'd65535;
            default: h = 16'($urandom_range(1, 6));
          endcase
          case ($urandom_range(0, 5))
            0: f = 16'd0;
            1: f = 16'($urandom_range(9, 40));
            default: f = 16'($urandom_range(1, 8));
          endcase
          set_gate(g, t, h, f);
        end
      endcase
      send_idle = ($urandom_range(0, 2) != 0);
      recv_idle = ($urandom_range(0, 2) != 0);
      amp = $urandom_range(2, 15);
      repeat (45) begin
        if ($urandom_range(0, 3) == 0) add_tick();
        else add_sample(draw_sample(amp));
      end
      drain();
    end

    // A frame length beyond the maximum acts as the maximum, so a short run
    // closes no frame; lowering the length then closes it on the next sample.
    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_gate(16'd1024, 16'($urandom_range(0, 65535)), 16'd3, 16'd8191);
    repeat (40) add_sample(draw_sample(15));
    drain();
    write_reg(agvg_pkg::CFG_FRAME_LENGTH, 16'd16);
    repeat (3) add_sample(draw_sample(15));
    add_tick();
    drain();

    while (gated_out_q.size() != 0) begin
      void'(gated_out_q.pop_front());
      report_err("expected result never arrived");
    end

    if (err_cnt == 0) begin
      $display("audio_gain_rms_voice_gate regression: pass");
    end else begin
      $display("audio_gain_rms_voice_gate regression: fail");
    end
    $finish;
  end

endmodule
